// ----- hdl/dtpm_pkg.sv -----
package dtpm_pkg;

    // Trie geometry
    localparam int NODES       = 1024;
    localparam int WORD_DIGITS = 20;
    localparam int RADIX       = 10;

    // Derived widths
    localparam int PTR_W     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W     = $clog2(NODES + 1);
    localparam int MATCH_W   = $clog2(WORD_DIGITS + 1);
    localparam int DIG_IDX_W = (RADIX > 1) ? $clog2(RADIX) : 1;

    // Word field widths
    localparam int MODE_W  = 2;
    localparam int DIGIT_W = 4;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 5;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // One node: a child pointer for each digit, zero means no child
    typedef logic [RADIX-1:0][PTR_W-1:0] t_row;

    // Write request into the node table
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] addr;
        t_row             data;
    } t_ram_wr;

endpackage

// ----- hdl/dtpm_row_ram.sv -----
module dtpm_row_ram (
    input  logic              i_clk,
    input  dtpm_pkg::t_ram_wr i_wr,
    input  logic [dtpm_pkg::PTR_W-1:0] i_raddr,
    output dtpm_pkg::t_row    o_rdata
);

    dtpm_pkg::t_row mem [dtpm_pkg::NODES];

    // Write one row, read one row with a registered output
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- hdl/digit_trie_prefix_match_unit.sv -----
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+--------------------------
// digit in | i_mode, i_digit, i_last                       | taken when start && !busy
// result   | o_kind, o_prefix_len, o_best_len, o_table_full | o_valid, one cycle, no stall
//
// For an insert or query digit the node row is read from the table at the
// accepting edge and the child pointer is used and written back in the next cycle.
// A mode 3 word is taken and does nothing.
// A clear word returns its result in the next cycle, then zeroes the table one node row
// a cycle, with busy high until every node row is zeroed.
// After reset the same clearing pass runs before the first word is taken.
// Results are never held off; each appears for one cycle with o_valid high.
module digit_trie_prefix_match_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dtpm_pkg::MODE_W-1:0]  i_mode,
    input  logic [dtpm_pkg::DIGIT_W-1:0] i_digit,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic [dtpm_pkg::KIND_W-1:0]  o_kind,
    output logic [dtpm_pkg::LEN_W-1:0]   o_prefix_len,
    output logic [dtpm_pkg::LEN_W-1:0]   o_best_len,
    output logic                         o_table_full
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_state                          r_state,    n_state;
    logic [dtpm_pkg::PTR_W-1:0]      r_cursor,   n_cursor;
    logic [dtpm_pkg::CNT_W-1:0]      r_node_cnt, n_node_cnt;
    logic [dtpm_pkg::MATCH_W-1:0]    r_match,    n_match;
    logic                            r_broken,   n_broken;
    logic [dtpm_pkg::MATCH_W-1:0]    r_best,     n_best;
    logic                            r_ovf,      n_ovf;
    logic [dtpm_pkg::PTR_W-1:0]      r_clr_idx,  n_clr_idx;
    logic                            r_valid,    n_valid;
    logic [dtpm_pkg::KIND_W-1:0]     r_kind,     n_kind;
    logic [dtpm_pkg::LEN_W-1:0]      r_pfx,      n_pfx;
    logic [dtpm_pkg::LEN_W-1:0]      r_best_out, n_best_out;
    logic                            r_full,     n_full;

    // Latched digit word
    logic [dtpm_pkg::MODE_W-1:0]     r_mode;
    logic [dtpm_pkg::DIGIT_W-1:0]    r_digit;
    logic                            r_last;

    dtpm_pkg::t_ram_wr               ram_wr;
    dtpm_pkg::t_row                  rd_row;

    logic                            accept;
    logic                            digit_ok;
    logic [dtpm_pkg::PTR_W-1:0]      child;
    logic [dtpm_pkg::PTR_W-1:0]      next_node;
    logic [dtpm_pkg::MATCH_W-1:0]    step_match;
    logic                            step_ovf;
    logic [dtpm_pkg::MATCH_W-1:0]    step_best;

    dtpm_row_ram u_row_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (r_cursor),
        .o_rdata (rd_row)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign digit_ok = ({1'b0, r_digit} < (dtpm_pkg::DIGIT_W + 1)'(dtpm_pkg::RADIX));
    assign child    = rd_row[r_digit[dtpm_pkg::DIG_IDX_W-1:0]];

    // Next state, table write and result
    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_node_cnt = r_node_cnt;
        n_match    = r_match;
        n_broken   = r_broken;
        n_best     = r_best;
        n_ovf      = r_ovf;
        n_clr_idx  = r_clr_idx;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_pfx      = r_pfx;
        n_best_out = r_best_out;
        n_full     = r_full;
        ram_wr     = '{we: 1'b0, addr: r_cursor, data: rd_row};
        next_node  = child;
        step_match = r_match;
        step_ovf   = r_ovf;
        step_best  = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode) inside
                        dtpm_pkg::MODE_INSERT, dtpm_pkg::MODE_QUERY: begin
                            n_state = S_EXEC;
                        end
                        dtpm_pkg::MODE_CLEAR: begin
                            n_state    = S_CLEAR;
                            n_clr_idx  = '0;
                            n_node_cnt = dtpm_pkg::CNT_W'(1);
                            n_best     = '0;
                            n_cursor   = '0;
                            n_match    = '0;
                            n_broken   = 1'b0;
                            n_ovf      = 1'b0;
                            n_valid    = 1'b1;
                            n_kind     = dtpm_pkg::KIND_CLEAR;
                            n_pfx      = '0;
                            n_best_out = '0;
                            n_full     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                // Walk one edge, allocating on a missing child when inserting and a node is free
                if (!r_broken) begin
                    if (!digit_ok) begin
                        n_broken = 1'b1;
                    end else begin
                        if (child == '0 && r_mode == dtpm_pkg::MODE_INSERT) begin
                            if (r_node_cnt < dtpm_pkg::CNT_W'(dtpm_pkg::NODES)) begin
                                next_node  = r_node_cnt[dtpm_pkg::PTR_W-1:0];
                                n_node_cnt = r_node_cnt + 1'b1;
                                ram_wr.we  = 1'b1;
                                ram_wr.data[r_digit[dtpm_pkg::DIG_IDX_W-1:0]] =
                                    r_node_cnt[dtpm_pkg::PTR_W-1:0];
                            end else begin
                                step_ovf = 1'b1;
                            end
                        end
                        if (next_node == '0) begin
                            n_broken = 1'b1;
                        end else begin
                            n_cursor = next_node;
                            if (r_match < dtpm_pkg::MATCH_W'(dtpm_pkg::WORD_DIGITS)) begin
                                step_match = r_match + 1'b1;
                            end
                        end
                    end
                end
                n_match = step_match;
                n_ovf   = step_ovf;

                // Report and drop the word on its last digit
                if (r_last) begin
                    n_valid = 1'b1;
                    if (r_mode == dtpm_pkg::MODE_QUERY) begin
                        if (step_match > r_best) begin
                            step_best = step_match;
                        end
                        n_best     = step_best;
                        n_kind     = dtpm_pkg::KIND_QUERY;
                        n_pfx      = dtpm_pkg::LEN_W'(step_match);
                        n_best_out = dtpm_pkg::LEN_W'(step_best);
                        n_full     = 1'b0;
                    end else begin
                        n_kind     = dtpm_pkg::KIND_INSERT;
                        n_pfx      = '0;
                        n_best_out = dtpm_pkg::LEN_W'(r_best);
                        n_full     = step_ovf;
                    end
                    n_cursor = '0;
                    n_match  = '0;
                    n_broken = 1'b0;
                    n_ovf    = 1'b0;
                end
            end

            S_CLEAR: begin
                // Zero one node row a cycle
                ram_wr = '{we: 1'b1, addr: r_clr_idx, data: '0};
                if (r_clr_idx == dtpm_pkg::PTR_W'(dtpm_pkg::NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cursor   <= '0;
            r_node_cnt <= dtpm_pkg::CNT_W'(1);
            r_match    <= '0;
            r_broken   <= 1'b0;
            r_best     <= '0;
            r_ovf      <= 1'b0;
            r_clr_idx  <= '0;
            r_valid    <= 1'b0;
            r_kind     <= dtpm_pkg::KIND_INSERT;
            r_pfx      <= '0;
            r_best_out <= '0;
            r_full     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_node_cnt <= n_node_cnt;
            r_match    <= n_match;
            r_broken   <= n_broken;
            r_best     <= n_best;
            r_ovf      <= n_ovf;
            r_clr_idx  <= n_clr_idx;
            r_valid    <= n_valid;
            r_kind     <= n_kind;
            r_pfx      <= n_pfx;
            r_best_out <= n_best_out;
            r_full     <= n_full;
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_digit <= i_digit;
            r_last  <= i_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_prefix_len = r_pfx;
    assign o_best_len   = r_best_out;
    assign o_table_full = r_full;

`ifndef SYNTHESIS
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_EXEC) ||
                    ($past(accept) && $past(i_mode) == dtpm_pkg::MODE_CLEAR))
        else $error("result without a finished word or clear");

    a_node_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_node_cnt != '0) && (r_node_cnt <= dtpm_pkg::CNT_W'(dtpm_pkg::NODES)))
        else $error("node count out of range");

    a_match_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match <= dtpm_pkg::MATCH_W'(dtpm_pkg::WORD_DIGITS))
        else $error("match length past saturation");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr.we && r_state == S_EXEC) |=> r_node_cnt == $past(r_node_cnt) + 1'b1)
        else $error("node written without allocation");

    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && i_mode == dtpm_pkg::MODE_CLEAR) |=> r_best >= $past(r_best))
        else $error("best length dropped without a clear");
`endif

endmodule
